/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the corner turner checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk, ignored while rst is high.
`define MTC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising edge of clk, also while rst is high.
`define MTC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/mtc_pkg.sv */
// ----------------------------------------------------------------------------
// Corner turner package
// Widths, defaults and register codes of the matrix transpose unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mtc_pkg;

  // Raw element word width (real and imaginary each).
  localparam int unsigned WORD_W = 64;

  // Width of the row and column count registers.
  localparam int unsigned DIM_W = 11;

  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = DIM_W;

  // Default bank depth in elements.
  localparam int unsigned DEFAULT_MAX_ELEMS = 1024;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 2'd0,
    CFG_COL_COUNT = 2'd1,
    CFG_CONJ_MODE = 2'd2,
    CFG_CPLX_MODE = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

/* hw/rtl/mtc_stream_if.sv */
// ----------------------------------------------------------------------------
// Corner turner stream interfaces
// Valid/ready channels for input elements and transposed results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtc_elem_if;
  import mtc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] elem_real;
  logic [WORD_W-1:0] elem_imag;
  logic              flush_only;

  modport source (output valid, output elem_real, output elem_imag, output flush_only,
                  input ready);
  modport sink   (input valid, input elem_real, input elem_imag, input flush_only,
                  output ready);
endinterface

interface mtc_result_if;
  import mtc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_real;
  logic [WORD_W-1:0] out_imag;
  logic              last_of_matrix;

  modport source (output valid, output out_real, output out_imag, output last_of_matrix,
                  input ready);
  modport sink   (input valid, input out_real, input out_imag, input last_of_matrix,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/matrix_transpose_conjugate_unit.sv */
// ----------------------------------------------------------------------------
// Matrix transpose / conjugate corner turner
// Ping-pong two-bank transpose with optional Hermitian conjugate on output.
// ----------------------------------------------------------------------------
// Elements of a row_count x col_count matrix enter in row-major order and are
// written into the fill bank; at the same time the previous complete matrix
// is read from the other bank in column-major order, one result per input
// transaction, and the banks swap when a matrix is complete. The unit takes
// one transaction per clock cycle while no stalled result holds the read
// stage; a result passes through the registered read of the bank memory and
// then the output register. The rate is set by the single write port and
// single read port of the bank memory, each used at most once per
// transaction. Each bank holds MAX_ELEMS words of 128 bits; its contents are
// undefined until written and there is no clearing pass after reset. A flush
// transaction writes nothing and only drains. Configuration may be written
// only while no result is outstanding.
`default_nettype none

module matrix_transpose_conjugate_unit #(
  parameter int unsigned MAX_ELEMS = mtc_pkg::DEFAULT_MAX_ELEMS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [mtc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mtc_pkg::CFG_DATA_W-1:0]  cfg_data,
  mtc_elem_if.sink                        in_ch,
  mtc_result_if.source                    out_ch
);
  import mtc_pkg::*;

  localparam int unsigned AW     = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int unsigned POS_W  = DIM_W;
  localparam int unsigned PROD_W = 2 * DIM_W;
  localparam logic [PROD_W-1:0] LAST_ADDR = PROD_W'(MAX_ELEMS - 1);
  localparam logic [PROD_W-1:0] MAX_TOTAL = PROD_W'(MAX_ELEMS);

  // Configuration registers
  logic [DIM_W-1:0] row_count;
  logic [DIM_W-1:0] col_count;
  logic             conjugate_mode;
  logic             complex_mode;

  // Fill and drain state
  logic [AW-1:0]    fill_index, fill_index_next;
  logic             fill_bank, fill_bank_next;
  logic [POS_W-1:0] drain_row, drain_row_next;
  logic [POS_W-1:0] drain_col, drain_col_next;
  logic             drain_pending, drain_pending_next;

  // Bank memories
  logic [WORD_W-1:0] mem_real [2][MAX_ELEMS];
  logic [WORD_W-1:0] mem_imag [2][MAX_ELEMS];

  // Read stage and output register
  logic              s1_valid;
  logic              s1_last;
  logic [WORD_W-1:0] rd_real;
  logic [WORD_W-1:0] rd_imag;
  logic              out_valid;
  logic [WORD_W-1:0] out_real;
  logic [WORD_W-1:0] out_imag;
  logic              out_last;

  // Datapath
  logic [DIM_W-1:0]  dim_m;
  logic [DIM_W-1:0]  dim_n;
  logic [DIM_W-1:0]  row_ext;
  logic [DIM_W-1:0]  col_ext;
  logic [DIM_W-1:0]  row_inc;
  logic [DIM_W-1:0]  col_inc;
  logic              in_shape;
  logic              produce;
  logic              drain_last;
  logic [PROD_W-1:0] addr_full;
  logic [AW-1:0]     rd_addr;
  logic [PROD_W-1:0] total_full;
  logic [PROD_W-1:0] total;
  logic [PROD_W-1:0] fill_inc;
  logic              fill_done;
  logic              s1_adv;
  logic              in_ready;
  logic              accept;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count      <= DIM_W'(1);
      col_count      <= DIM_W'(1);
      conjugate_mode <= 1'b0;
      complex_mode   <= 1'b1;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ROW_COUNT: row_count      <= cfg_data;
        CFG_COL_COUNT: col_count      <= cfg_data;
        CFG_CONJ_MODE: conjugate_mode <= cfg_data[0];
        CFG_CPLX_MODE: complex_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective shape: a zero count acts as one
  assign dim_m = (row_count == '0) ? DIM_W'(1) : row_count;
  assign dim_n = (col_count == '0) ? DIM_W'(1) : col_count;

  // Drain position and read address
  assign row_ext    = drain_row;
  assign col_ext    = drain_col;
  assign row_inc    = row_ext + DIM_W'(1);
  assign col_inc    = col_ext + DIM_W'(1);
  assign in_shape   = (row_ext < dim_m) && (col_ext < dim_n);
  assign produce    = drain_pending && in_shape;
  assign drain_last = (row_inc >= dim_m) && (col_inc >= dim_n);
  assign addr_full  = PROD_W'(drain_row) * PROD_W'(dim_n) + PROD_W'(drain_col);
  assign rd_addr    = (addr_full > LAST_ADDR) ? AW'(LAST_ADDR) : addr_full[AW-1:0];

  // Matrix size, capped at the bank depth
  assign total_full = PROD_W'(dim_m) * PROD_W'(dim_n);
  assign total      = (total_full > MAX_TOTAL) ? MAX_TOTAL : total_full;
  assign fill_inc   = PROD_W'(fill_index) + PROD_W'(1);
  assign fill_done  = fill_inc >= total;

  // Handshake: a waiting result holds the read stage, which then holds the input
  assign s1_adv   = s1_valid && (!out_valid || out_ch.ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_ch.valid && in_ready;

  // Next fill and drain state
  always_comb begin
    fill_index_next    = fill_index;
    fill_bank_next     = fill_bank;
    drain_row_next     = drain_row;
    drain_col_next     = drain_col;
    drain_pending_next = drain_pending;
    if (accept) begin
      // advance the column-major drain, or drop a drain outside the shape
      if (produce) begin
        if (row_inc >= dim_m) begin
          drain_row_next = '0;
          if (col_inc >= dim_n) begin
            drain_col_next     = '0;
            drain_pending_next = 1'b0;
          end else begin
            drain_col_next = col_inc[POS_W-1:0];
          end
        end else begin
          drain_row_next = row_inc[POS_W-1:0];
        end
      end else begin
        drain_pending_next = 1'b0;
      end
      // advance the fill; a complete matrix swaps banks and restarts the drain
      if (!in_ch.flush_only) begin
        if (fill_done) begin
          fill_index_next    = '0;
          fill_bank_next     = ~fill_bank;
          drain_pending_next = 1'b1;
          drain_row_next     = '0;
          drain_col_next     = '0;
        end else begin
          fill_index_next = fill_inc[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_index    <= '0;
      fill_bank     <= 1'b0;
      drain_row     <= '0;
      drain_col     <= '0;
      drain_pending <= 1'b0;
    end else begin
      fill_index    <= fill_index_next;
      fill_bank     <= fill_bank_next;
      drain_row     <= drain_row_next;
      drain_col     <= drain_col_next;
      drain_pending <= drain_pending_next;
    end
  end

  // Bank memories: write the fill bank, read the drain bank.
  // fill_index stays below the capped matrix size, so it never leaves the bank.
  always_ff @(posedge clk) begin
    if (accept && !in_ch.flush_only) begin
      mem_real[fill_bank][fill_index] <= in_ch.elem_real;
      mem_imag[fill_bank][fill_index] <= in_ch.elem_imag;
    end
    if (accept && produce) begin
      rd_real <= mem_real[~fill_bank][rd_addr];
      rd_imag <= mem_imag[~fill_bank][rd_addr];
      s1_last <= drain_last;
    end
  end

  // Read stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= produce;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload: flip the imaginary sign bit for conjugate, zero the imaginary part in real mode
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_real <= rd_real;
      out_imag <= complex_mode ?
                  {rd_imag[WORD_W-1] ^ conjugate_mode, rd_imag[WORD_W-2:0]} : '0;
      out_last <= s1_last;
    end
  end

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.out_real       = out_real;
  assign out_ch.out_imag       = out_imag;
  assign out_ch.last_of_matrix = out_last;

endmodule

`default_nettype wire

/* hw/rtl/mtc_checker.sv */
// ----------------------------------------------------------------------------
// Corner turner port checker
// Watches the ports of the transpose unit for handshake and timing slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mtc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mtc_pkg::WORD_W-1:0]    out_real,
  input logic [mtc_pkg::WORD_W-1:0]    out_imag,
  input logic                          out_last
);

  // Hold a stalled result
  `MTC_ASSERT(a_out_valid_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `MTC_ASSERT(a_out_payload_hold, clk, rst, out_valid && !out_ready |=> $stable(out_real) && $stable(out_imag) && $stable(out_last), "stalled result changed")

  // Input stalls only behind a stalled result
  `MTC_ASSERT(a_in_stall_cause, clk, rst, !in_ready |-> out_valid && !out_ready, "input stalled without output backpressure")

  // A new result follows an accepted transaction through the read stage and the output register
  `MTC_ASSERT(a_out_latency, clk, rst, $rose(out_valid) |-> $past(in_valid && in_ready && !rst, 2), "result without accepted transaction")

  // Drop any result on reset
  `MTC_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind matrix_transpose_conjugate_unit mtc_checker u_mtc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_real  (out_ch.out_real),
  .out_imag  (out_ch.out_imag),
  .out_last  (out_ch.last_of_matrix)
);

`default_nettype wire
